/* hw/rtl/bitmap_first_fit_page_allocator_top_macros.svh */
// Assertion macros shared by the page allocator RTL.
`ifndef BITMAP_FIRST_FIT_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_FIRST_FIT_PAGE_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define BFFPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define BFFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BFFPA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BFFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/bffpa_pkg.sv */
// Types and constants of the bitmap first-fit page allocator.
package bffpa_pkg;

  localparam int WORD_COUNT = 8192;
  localparam int WORD_BITS  = 64;
  localparam int BIT_W      = 6;
  localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int PIDX_W     = WADDR_W + BIT_W;
  localparam int PEND_W     = PIDX_W + 1;
  localparam int PAGE_W     = 36;
  localparam int CNT_W      = 20;
  localparam int ACT_W      = 2;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [PAGE_W:0]      page_ext_t;

  localparam word_t     FULL_WORD   = '1;
  localparam page_ext_t TOTAL_PAGES = page_ext_t'(WORD_COUNT * WORD_BITS);
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORD_COUNT - 1);
  localparam logic [BIT_W-1:0]   LAST_BIT  = BIT_W'(WORD_BITS - 1);

  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MARK  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_EVAL,
    ST_BIT,
    ST_RRD,
    ST_RMW
  } state_e;

endpackage

/* hw/rtl/bffpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bffpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/bitmap_first_fit_page_allocator_top.sv */
// Top level of the bitmap first-fit page allocator.
// Allocate: reads the bitmap words in order, takes a free or full word whole and scans a
//   partly used word bit by bit, then marks each bitmap word the run touches (bitmap RAM port).
// Free and mark: each word touched is updated by read-modify-write.
// Invalid: no bitmap step. done_o pulses after the last step; the next start_i is taken then.
// After reset busy_o stays high while the bitmap is cleared word by word.
`include "bitmap_first_fit_page_allocator_top_macros.svh"

module bitmap_first_fit_page_allocator_top
  import bffpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PAGE_W-1:0] cfg_wdata_i,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [PAGE_W-1:0] page_number_i,
  input  logic [CNT_W-1:0]  page_count_i,
  output logic              done_o,
  output logic [PAGE_W-1:0] result_page_o,
  output logic              ok_o
);

  state_e              state_q, state_d;
  logic [WADDR_W-1:0]  clr_q, clr_d;
  logic                done_q, done_d;
  logic [PAGE_W-1:0]   base_q;
  logic [WADDR_W-1:0]  w_q, w_d;
  logic [BIT_W-1:0]    b_q, b_d;
  logic [CNT_W-1:0]    run_q, run_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [PIDX_W-1:0]   first_q, first_d;
  word_t               word_q, word_d;
  logic [PIDX_W-1:0]   rs_q, rs_d;
  logic [PEND_W-1:0]   re_q, re_d;
  logic                setb_q, setb_d;
  logic [PAGE_W-1:0]   out_res_q, out_res_d;
  logic                out_ok_q, out_ok_d;

  logic                ram_we;
  logic [WADDR_W-1:0]  ram_waddr;
  word_t               ram_wdata;
  logic [WADDR_W-1:0]  ram_raddr;
  word_t               ram_rdata;

  logic [PAGE_W-1:0]   diff;
  page_ext_t           diff_ext;
  page_ext_t           sum_ext;
  logic                range_ok;
  logic [PEND_W-1:0]   range_end;
  logic [PEND_W-1:0]   re_m1;
  logic [WADDR_W-1:0]  cur_word;
  logic [WADDR_W-1:0]  end_word;
  logic [BIT_W-1:0]    lo_bit;
  logic [BIT_W-1:0]    hi_bit;
  word_t               ram_mask;

  assign diff      = page_number_i - base_q;
  assign diff_ext  = page_ext_t'(diff);
  assign sum_ext   = diff_ext + page_ext_t'(page_count_i);
  assign range_ok  = (page_number_i >= base_q) && (diff_ext < TOTAL_PAGES) &&
                     (page_count_i != '0);
  assign range_end = (sum_ext > TOTAL_PAGES) ? PEND_W'(TOTAL_PAGES) : PEND_W'(sum_ext);

  assign re_m1     = re_q - PEND_W'(1);
  assign cur_word  = rs_q[PIDX_W-1:BIT_W];
  assign end_word  = re_m1[PIDX_W-1:BIT_W];
  assign lo_bit    = rs_q[BIT_W-1:0];
  assign hi_bit    = (cur_word == end_word) ? re_m1[BIT_W-1:0] : LAST_BIT;
  assign ram_mask  = (FULL_WORD << lo_bit) & (FULL_WORD >> (LAST_BIT - hi_bit));

  always_comb begin
    logic              found;
    logic              fail;
    logic [PIDX_W-1:0] fpage;
    logic [CNT_W:0]    run_sum;

    state_d   = state_q;
    clr_d     = clr_q;
    done_d    = 1'b0;
    w_d       = w_q;
    b_d       = b_q;
    run_d     = run_q;
    count_d   = count_q;
    first_d   = first_q;
    word_d    = word_q;
    rs_d      = rs_q;
    re_d      = re_q;
    setb_d    = setb_q;
    out_res_d = out_res_q;
    out_ok_d  = out_ok_q;
    found     = 1'b0;
    fail      = 1'b0;
    fpage     = first_q;
    run_sum   = (CNT_W+1)'(run_q) + (CNT_W+1)'(WORD_BITS);

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + WADDR_W'(1);
        if (clr_q == LAST_WORD) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          unique case (action_i) inside
            ACT_ALLOC: begin
              out_res_d = '0;
              out_ok_d  = 1'b0;
              count_d   = page_count_i;
              if ((page_count_i == '0) || (page_ext_t'(page_count_i) > TOTAL_PAGES)) begin
                done_d = 1'b1;
              end else begin
                w_d     = '0;
                run_d   = '0;
                first_d = '0;
                state_d = ST_RD;
              end
            end
            ACT_FREE, ACT_MARK: begin
              out_res_d = '0;
              out_ok_d  = 1'b1;
              setb_d    = (action_i == ACT_MARK);
              if (range_ok) begin
                rs_d    = diff[PIDX_W-1:0];
                re_d    = range_end;
                state_d = ST_RRD;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              out_res_d = '0;
              out_ok_d  = 1'b0;
              done_d    = 1'b1;
            end
          endcase
        end
      end
      ST_RD: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (ram_rdata == FULL_WORD) begin
          run_d = '0;
          if (w_q == LAST_WORD) begin
            fail = 1'b1;
          end else begin
            w_d = w_q + WADDR_W'(1);
          end
        end else if (ram_rdata == '0) begin
          fpage   = (run_q == '0) ? {w_q, BIT_W'(0)} : first_q;
          first_d = fpage;
          if (run_sum >= (CNT_W+1)'(count_q)) begin
            found = 1'b1;
          end else begin
            run_d = CNT_W'(run_sum);
            if (w_q == LAST_WORD) begin
              fail = 1'b1;
            end else begin
              w_d = w_q + WADDR_W'(1);
            end
          end
        end else begin
          word_d  = ram_rdata;
          b_d     = '0;
          state_d = ST_BIT;
        end
      end
      ST_BIT: begin
        if (word_q[b_q]) begin
          run_d = '0;
        end else begin
          fpage   = (run_q == '0) ? {w_q, b_q} : first_q;
          first_d = fpage;
          if ((run_q + CNT_W'(1)) == count_q) begin
            found = 1'b1;
          end else begin
            run_d = run_q + CNT_W'(1);
          end
        end
        if (!found) begin
          if (b_q == LAST_BIT) begin
            if (w_q == LAST_WORD) begin
              fail = 1'b1;
            end else begin
              w_d     = w_q + WADDR_W'(1);
              state_d = ST_RD;
            end
          end else begin
            b_d = b_q + BIT_W'(1);
          end
        end
      end
      ST_RRD: begin
        state_d = ST_RMW;
      end
      ST_RMW: begin
        if (cur_word == end_word) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          rs_d    = {cur_word + WADDR_W'(1), BIT_W'(0)};
          state_d = ST_RRD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (found) begin
      out_res_d = base_q + PAGE_W'(fpage);
      out_ok_d  = 1'b1;
      rs_d      = fpage;
      re_d      = PEND_W'(fpage) + PEND_W'(count_q);
      setb_d    = 1'b1;
      state_d   = ST_RRD;
    end
    if (fail) begin
      done_d  = 1'b1;
      state_d = ST_IDLE;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_word;
    ram_wdata = setb_q ? (ram_rdata | ram_mask) : (ram_rdata & ~ram_mask);
    ram_raddr = w_q;
    busy_o    = (state_q != ST_IDLE);
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_EVAL: begin
        ram_raddr = w_q + WADDR_W'(1);
      end
      ST_RRD: begin
        ram_raddr = cur_word;
      end
      ST_RMW: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_raddr = w_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
      base_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q       <= w_d;
    b_q       <= b_d;
    run_q     <= run_d;
    count_q   <= count_d;
    first_q   <= first_d;
    word_q    <= word_d;
    rs_q      <= rs_d;
    re_q      <= re_d;
    setb_q    <= setb_d;
    out_res_q <= out_res_d;
    out_ok_q  <= out_ok_d;
  end

  bffpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o        = done_q;
  assign result_page_o = out_res_q;
  assign ok_o          = out_ok_q;

  `BFFPA_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, start_i && !busy_o, busy_o || done_o)
  `BFFPA_ASSERT_IMPL(a_fail_zero, clk_i, rst_ni, done_o && !ok_o, result_page_o == '0)
  `BFFPA_ASSERT_IMPL(a_scan_no_write, clk_i, rst_ni,
                     (state_q == ST_EVAL) || (state_q == ST_BIT), !ram_we)
  `BFFPA_ASSERT_IMPL(a_mask_nonempty, clk_i, rst_ni, state_q == ST_RMW, ram_mask != '0)

endmodule

/* dv/testbench.sv */
// Self-checking testbench of the page allocator: directed table, then random requests.
`timescale 1ns / 100ps

module testbench;
  import bffpa_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              ok;
  } reply_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [PAGE_W-1:0] page_number;
    logic [CNT_W-1:0]  page_count;
    logic              known;
    logic [PAGE_W-1:0] page;
    logic              ok;
  } dir_row_t;

  localparam logic [ACT_W-1:0]  ACT_NONE  = 2'd3;
  localparam logic [PAGE_W-1:0] PAGE_MAX  = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
  localparam logic [CNT_W-1:0]  MAP_PAGES = CNT_W'(WORD_COUNT * WORD_BITS);
  localparam u64_t              MAP_SIZE  = u64_t'(WORD_COUNT) * u64_t'(WORD_BITS);
  localparam logic [PAGE_W-1:0] DIR_BASE  = 36'h0_0000_1000;
  localparam int WATCHDOG_LIMIT = 4 * WORD_COUNT * (WORD_BITS + 8);
  localparam int DRAIN_CYCLES   = 200;
  localparam int DIR_ROWS       = 24;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [PAGE_W-1:0] cfg_wdata_i   = '0;
  logic              start_i       = 1'b0;
  logic [ACT_W-1:0]  action_i      = ACT_ALLOC;
  logic [PAGE_W-1:0] page_number_i = '0;
  logic [CNT_W-1:0]  page_count_i  = '0;
  logic              busy_o;
  logic              done_o;
  logic [PAGE_W-1:0] result_page_o;
  logic              ok_o;

  logic   row_known = 1'b0;
  reply_t row_reply = '0;

  logic [WORD_BITS-1:0] page_map [WORD_COUNT];
  logic [PAGE_W-1:0]    page_base = '0;
  reply_t               replies_due [$];
  int                   errors = 0;
  int                   quiet_cycles = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ACT_ALLOC, 36'd0, 20'd0, 1'b1, 36'd0, 1'b0},
    '{ACT_ALLOC, 36'd0, 20'd1, 1'b1, DIR_BASE, 1'b1},
    '{ACT_ALLOC, 36'd0, 20'd3, 1'b1, DIR_BASE + 36'd1, 1'b1},
    '{ACT_ALLOC, 36'd0, MAP_PAGES, 1'b1, 36'd0, 1'b0},
    '{ACT_ALLOC, PAGE_MAX, CNT_MAX, 1'b1, 36'd0, 1'b0},
    '{ACT_FREE, 36'd0, 20'd5, 1'b1, 36'd0, 1'b1},
    '{ACT_FREE, DIR_BASE, 20'd1, 1'b1, 36'd0, 1'b1},
    '{ACT_ALLOC, 36'd0, 20'd1, 1'b1, DIR_BASE, 1'b1},
    '{ACT_MARK, DIR_BASE + 36'd524288, 20'd10, 1'b1, 36'd0, 1'b1},
    '{ACT_MARK, DIR_BASE + 36'd524287, 20'd100, 1'b1, 36'd0, 1'b1},
    '{ACT_FREE, DIR_BASE, 20'd0, 1'b1, 36'd0, 1'b1},
    '{ACT_NONE, PAGE_MAX, CNT_MAX, 1'b1, 36'd0, 1'b0},
    '{ACT_MARK, DIR_BASE + 36'd4, 20'd60, 1'b0, 36'd0, 1'b0},
    '{ACT_ALLOC, 36'd0, 20'd64, 1'b0, 36'd0, 1'b0},
    '{ACT_MARK, DIR_BASE + 36'd200, 20'd300, 1'b0, 36'd0, 1'b0},
    '{ACT_ALLOC, 36'd0, 20'd100, 1'b0, 36'd0, 1'b0},
    '{ACT_FREE, DIR_BASE, MAP_PAGES, 1'b1, 36'd0, 1'b1},
    '{ACT_ALLOC, 36'd0, MAP_PAGES, 1'b1, DIR_BASE, 1'b1},
    '{ACT_ALLOC, 36'd0, 20'd1, 1'b1, 36'd0, 1'b0},
    '{ACT_FREE, PAGE_MAX, CNT_MAX, 1'b1, 36'd0, 1'b1},
    '{ACT_FREE, DIR_BASE + 36'd1000, CNT_MAX, 1'b1, 36'd0, 1'b1},
    '{ACT_ALLOC, 36'd0, 20'd1000, 1'b0, 36'd0, 1'b0},
    '{ACT_FREE, DIR_BASE, 20'd2000, 1'b0, 36'd0, 1'b0},
    '{ACT_ALLOC, 36'd0, 20'd2, 1'b0, 36'd0, 1'b0}
  };

  always #10 clk_i = ~clk_i;

  bitmap_first_fit_page_allocator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .action_i      (action_i),
    .page_number_i (page_number_i),
    .page_count_i  (page_count_i),
    .done_o        (done_o),
    .result_page_o (result_page_o),
    .ok_o          (ok_o)
  );

  function automatic void set_pages(u64_t first, u64_t count, logic used);
    u64_t p;
    p = first;
    while (count != 0 && p < MAP_SIZE) begin
      page_map[int'(p / u64_t'(WORD_BITS))][int'(p % u64_t'(WORD_BITS))] = used;
      p++;
      count--;
    end
  endfunction

  function automatic logic first_fit(u64_t count, output u64_t first);
    u64_t run;
    run = 0;
    first = 0;
    if (count == 0 || count > MAP_SIZE) return 1'b0;
    for (int w = 0; w < WORD_COUNT; w++) begin
      if (page_map[w] == FULL_WORD) begin
        run = 0;
      end else if (page_map[w] == '0) begin
        if (run == 0) first = u64_t'(w) * u64_t'(WORD_BITS);
        if (run + u64_t'(WORD_BITS) >= count) return 1'b1;
        run += u64_t'(WORD_BITS);
      end else begin
        for (int b = 0; b < WORD_BITS; b++) begin
          if (page_map[w][b]) begin
            run = 0;
          end else begin
            if (run == 0) first = u64_t'(w) * u64_t'(WORD_BITS) + u64_t'(b);
            run++;
            if (run == count) return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic reply_t predict_reply(logic [ACT_W-1:0] act, logic [PAGE_W-1:0] pn,
                                           logic [CNT_W-1:0] cnt);
    reply_t            r;
    u64_t              first;
    logic [PAGE_W-1:0] offset;
    r = '0;
    if (act == ACT_ALLOC) begin
      if (first_fit(u64_t'(cnt), first)) begin
        set_pages(first, u64_t'(cnt), 1'b1);
        r.page = page_base + PAGE_W'(first);
        r.ok = 1'b1;
      end
    end else if (act == ACT_FREE || act == ACT_MARK) begin
      r.ok = 1'b1;
      if (pn >= page_base) begin
        offset = pn - page_base;
        set_pages(u64_t'(offset), u64_t'(cnt), act == ACT_MARK);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, u64_t got, u64_t want);
    errors++;
    $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni) begin
      if (done_o !== 1'b0) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected transaction", u64_t'(result_page_o), 0);
        end else begin
          want = replies_due.pop_front();
          if (result_page_o !== want.page)
            report_mismatch("result_page", u64_t'(result_page_o), u64_t'(want.page));
          if (ok_o !== want.ok)
            report_mismatch("ok", u64_t'(ok_o), u64_t'(want.ok));
        end
      end
      if (start_i && busy_o === 1'b0) begin
        want = predict_reply(action_i, page_number_i, page_count_i);
        if (row_known) want = row_reply;
        replies_due.push_back(want);
      end
      if ((start_i && busy_o === 1'b0) || done_o !== 1'b0) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send(logic [ACT_W-1:0] act, logic [PAGE_W-1:0] pn, logic [CNT_W-1:0] cnt,
                      logic known, reply_t lit, int idle_pct);
    while (int'($urandom_range(0, 99)) < idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    start_i       <= 1'b1;
    action_i      <= act;
    page_number_i <= pn;
    page_count_i  <= cnt;
    row_known     <= known;
    row_reply     <= lit;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  task automatic write_base(logic [PAGE_W-1:0] value);
    @(negedge clk_i);
    start_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    page_base = value;
  endtask

  task automatic random_request(int idle_pct);
    logic [ACT_W-1:0]  act;
    logic [PAGE_W-1:0] pn;
    logic [CNT_W-1:0]  cnt;
    logic [3:0]        hi;
    logic [31:0]       lo;
    int                roll;
    roll = $urandom_range(0, 99);
    act = roll < 45 ? ACT_ALLOC : roll < 70 ? ACT_FREE : roll < 95 ? ACT_MARK : ACT_NONE;
    hi = 4'($urandom_range(0, 15));
    lo = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 70) pn = page_base + PAGE_W'($urandom_range(0, 4095));
    else if (roll < 80) pn = page_base - PAGE_W'($urandom_range(1, 64));
    else if (roll < 92) pn = {hi, lo};
    else pn = page_base + PAGE_W'($urandom_range(4096, 600000));
    roll = $urandom_range(0, 99);
    if (act == ACT_ALLOC) begin
      if (roll < 72) cnt = CNT_W'($urandom_range(1, 70));
      else if (roll < 84) cnt = CNT_W'($urandom_range(71, 1500));
      else if (roll < 90) cnt = '0;
      else cnt = CNT_W'($urandom_range(0, 1048575));
    end else begin
      if (roll < 70) cnt = CNT_W'($urandom_range(1, 200));
      else if (roll < 85) cnt = CNT_W'($urandom_range(1, 4096));
      else if (roll < 93) cnt = CNT_W'($urandom_range(0, 1048575));
      else cnt = '0;
    end
    send(act, pn, cnt, 1'b0, '0, idle_pct);
  endtask

  initial begin
    logic [PAGE_W-1:0] mid_base;
    foreach (page_map[i]) page_map[i] = '0;
    mid_base = {4'($urandom_range(0, 15)), 32'($urandom)};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_base(DIR_BASE);
    foreach (dir_rows[i])
      send(dir_rows[i].action, dir_rows[i].page_number, dir_rows[i].page_count,
           dir_rows[i].known, '{page: dir_rows[i].page, ok: dir_rows[i].ok}, 0);

    write_base(PAGE_MAX);
    repeat (26) random_request(12);
    write_base(mid_base);
    repeat (26) random_request(79);
    write_base('0);
    repeat (26) random_request(0);

    @(negedge clk_i);
    start_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
